// ----- rtl/hbc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared widths, register indexes, reset values and helpers for the
// histogram bar chart block.
// ----------------------------------------------------------------------------
package hbc_pkg;

  localparam int DATA_W       = 32;
  localparam int BAR_W        = 8;
  localparam int PROD_W       = DATA_W + BAR_W;
  localparam int STEP_W       = $clog2(BAR_W);
  localparam int CFG_IDX_W    = 2;
  localparam int NUM_BINS_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_WIDTH = 2'd2;

  localparam logic [DATA_W-1:0] RANGE_LO_RST  = 32'd1;
  localparam logic [DATA_W-1:0] RANGE_HI_RST  = 32'd20;
  localparam logic [BAR_W-1:0]  BAR_WIDTH_RST = 8'd60;

  localparam logic ACTION_ADD    = 1'b0;
  localparam logic ACTION_REPORT = 1'b1;

  // Saturating increment: stop at all ones.
  function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
    sat_inc = (v == {DATA_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hbc_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hbc_divider
// Restoring divider, one quotient bit per cycle. The caller guarantees
// numer < 2**BAR_W * denom, so the quotient fits BAR_W bits.
// ----------------------------------------------------------------------------
module hbc_divider
  import hbc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] numer,
  input  wire logic [DATA_W-1:0] denom,
  output logic                   done,
  output logic [BAR_W-1:0]       quot
);

  logic [DATA_W-1:0] rem;
  logic [BAR_W-1:0]  low;
  logic              run;
  logic [STEP_W-1:0] step;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  assign trial = {rem, low[BAR_W-1]};
  assign diff  = trial - {1'b0, denom};
  assign fits  = (trial >= {1'b0, denom});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        if (step == STEP_W'(BAR_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= numer[PROD_W-1:BAR_W];
      low <= numer[BAR_W-1:0];
    end else if (run) begin
      rem  <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      low  <= {low[BAR_W-2:0], 1'b0};
      quot <= {quot[BAR_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/histogram_bar_chart_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_bar_chart_top
// Histogram of signed samples with a scaled bar chart report.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   -------------------------  ----------------------------------
//  input     start & !busy              action, sample_value
//  result    result_strobe (one cycle)  bin_value, bin_count, bar_dots,
//                                       out_of_range_count, is_summary, last
//  config    cfg_write                  cfg_index, cfg_data
//
//  Sequence: an out-of-range sample only bumps the out-of-range count; an
//  in-range sample does one read-modify-write of the bin memory. A report is
//  accepted, then each bin line passes S_RD, S_MUL, S_DIV (bit-serial bar
//  divider, only when the peak is nonzero) and S_OUT, then the summary word
//  is shown, then S_CLEAR zeroes the bins that the report did not visit.
//  Reset: synchronous; afterwards a clearing pass zeroes every bin of the
//  bin memory while busy is high. Config writes are taken at any time.
//  Stalls: the receiver cannot stall; each result word is shown once.
// ----------------------------------------------------------------------------
module histogram_bar_chart_top
  import hbc_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input word
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 action,
  input  wire logic signed [DATA_W-1:0] sample_value,
  // config port
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data,
  // result word
  output logic                      result_strobe,
  output logic signed [DATA_W-1:0]  bin_value,
  output logic [DATA_W-1:0]         bin_count,
  output logic [BAR_W-1:0]          bar_dots,
  output logic [DATA_W-1:0]         out_of_range_count,
  output logic                      is_summary,
  output logic                      last
);

  localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CNT_W = $clog2(NUM_BINS + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ADD   = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_OUT   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_CLEAR = 8'b1000_0000
  } state_t;

  state_t state;

  // Config registers
  logic [DATA_W-1:0] range_lo;
  logic [DATA_W-1:0] range_hi;
  logic [BAR_W-1:0]  bar_width;

  // Counters outside the bin memory
  logic [DATA_W-1:0] oor_total;
  logic [DATA_W-1:0] peak;

  // Sequencer registers
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  lines;
  logic [IDX_W-1:0]  add_idx;
  logic [DATA_W-1:0] cnt_hold;
  logic [BAR_W-1:0]  dots;

  // Bin memory
  logic [DATA_W-1:0] mem [NUM_BINS];
  logic [DATA_W-1:0] rdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  // Accept-cycle decode
  logic              accept;
  logic [DATA_W:0]   offset;
  logic              in_range;
  logic [DATA_W+1:0] span;
  logic [CNT_W-1:0]  lines_next;
  logic [DATA_W-1:0] inc_val;

  // Divider hookup
  logic              div_start;
  logic              div_done;
  logic [BAR_W-1:0]  div_quot;
  logic [PROD_W-1:0] product;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Offset from the low bound, sign-extended so that the borrow marks a
  // sample below it.
  assign offset   = {sample_value[DATA_W-1], sample_value}
                  - {range_lo[DATA_W-1], range_lo};
  assign in_range = !offset[DATA_W]
                 && ($signed(sample_value) <= $signed(range_hi))
                 && (offset[DATA_W-1:0] < DATA_W'(NUM_BINS));

  // Number of bin lines: clamp high - low + 1 to 0..NUM_BINS.
  assign span = {{2{range_hi[DATA_W-1]}}, range_hi}
              - {{2{range_lo[DATA_W-1]}}, range_lo} + 1'b1;

  always_comb begin
    if (span[DATA_W+1] || (span == '0)) begin
      lines_next = '0;
    end else if (span > (DATA_W+2)'(NUM_BINS)) begin
      lines_next = CNT_W'(NUM_BINS);
    end else begin
      lines_next = span[CNT_W-1:0];
    end
  end

  assign inc_val = sat_inc(rdata);

  // Memory port steering
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = offset[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = idx[IDX_W-1:0];
    mem_wdata = '0;
    case (state)
      S_IDLE: begin
        mem_re = accept && (action == ACTION_ADD) && in_range;
      end
      S_ADD: begin
        mem_we    = 1'b1;
        mem_waddr = add_idx;
        mem_wdata = inc_val;
      end
      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx[IDX_W-1:0];
      end
      S_MUL, S_CLEAR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Scale the bin count: count * bar_width / peak, one quotient bit a cycle.
  assign product   = rdata * bar_width;
  assign div_start = (state == S_MUL) && (peak != '0);

  hbc_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (product),
    .denom (peak),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Config writes; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_lo  <= RANGE_LO_RST;
      range_hi  <= RANGE_HI_RST;
      bar_width <= BAR_WIDTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RANGE_LO:  range_lo  <= cfg_data;
        REG_RANGE_HI:  range_hi  <= cfg_data;
        REG_BAR_WIDTH: bar_width <= cfg_data[BAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      idx           <= '0;
      lines         <= '0;
      oor_total     <= '0;
      peak          <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (action == ACTION_ADD) begin
              if (in_range) begin
                state <= S_ADD;
              end else begin
                oor_total <= sat_inc(oor_total);
              end
            end else begin
              lines <= lines_next;
              idx   <= '0;
              state <= (lines_next == '0) ? S_SUM : S_RD;
            end
          end
        end
        S_ADD: begin
          // Write-back happens on the memory port; follow the largest bin.
          if (inc_val > peak) begin
            peak <= inc_val;
          end
          state <= S_IDLE;
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= (peak != '0) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          result_strobe <= 1'b1;
          if (CNT_W'(idx + 1'b1) == lines) begin
            state <= S_SUM;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_SUM: begin
          result_strobe <= 1'b1;
          oor_total     <= '0;
          peak          <= '0;
          idx           <= lines;
          state         <= (lines == CNT_W'(NUM_BINS)) ? S_IDLE : S_CLEAR;
        end
        S_CLEAR: begin
          // Zero the bins the report did not visit, or every bin after reset.
          if (idx == CNT_W'(NUM_BINS - 1)) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      add_idx <= offset[IDX_W-1:0];
    end
    if (state == S_MUL) begin
      cnt_hold <= rdata;
      dots     <= '0;
    end
    if ((state == S_DIV) && div_done) begin
      dots <= div_quot;
    end
  end

  // Result word registers
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      bin_value          <= range_lo + DATA_W'(idx);
      bin_count          <= cnt_hold;
      bar_dots           <= dots;
      out_of_range_count <= '0;
      is_summary         <= 1'b0;
      last               <= 1'b0;
    end else if (state == S_SUM) begin
      bin_value          <= '0;
      bin_count          <= '0;
      bar_dots           <= '0;
      out_of_range_count <= oor_total;
      is_summary         <= 1'b1;
      last               <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hbc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hbc_checker
// Port-level assertions for the histogram bar chart block.
// ----------------------------------------------------------------------------
module hbc_checker
  import hbc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic action,
  input wire logic result_strobe,
  input wire logic is_summary,
  input wire logic last
);

  // Leaving reset starts the clearing pass.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy)
    else $error("not busy after reset");

  // A report always occupies the block.
  a_report_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (action == ACTION_REPORT) |=> busy)
    else $error("report accepted but block idle");

  // A sample never produces a result word.
  a_add_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (action == ACTION_ADD) |=> !result_strobe)
    else $error("result after a sample");

  // Only the summary closes a report.
  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (last == is_summary))
    else $error("last and is_summary disagree");

  // More words pending keep the block busy.
  a_mid_report_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy)
    else $error("idle in the middle of a report");

endmodule

bind histogram_bar_chart_top hbc_checker u_hbc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .action        (action),
  .result_strobe (result_strobe),
  .is_summary    (is_summary),
  .last          (last)
);
`default_nettype wire
